/* rtl/core/tyr_pkg.sv */
// Shared types, constants and helper functions for the tiled YUV 4:2:0 to RGB565 converter.
package tyr_pkg;

	// Picture geometry limits.
	localparam int MAX_TILES_ACROSS = 128;
	localparam int MAX_TILES_DOWN   = 128;
	localparam int TILE_W           = 7;   // tile column / tile row counter width
	localparam int COUNT_W          = 8;   // width of a tile count register
	localparam int LINE_W           = 5;   // line within a 32-line tile
	localparam int PAIR_W           = 4;   // pixel pair within a 32-pixel tile line
	localparam int POS_W            = 12;  // row and column of a pixel
	localparam int CROP_W           = 13;  // crop registers, 0..4096
	localparam int STRIDE_W         = 13;  // raster stride, 32 * tiles_across
	localparam int INDEX_W          = 24;  // raster destination index
	localparam int SUM_W            = 20;  // signed color sums before scaling

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TILES_ACROSS = 3'd0,
		REG_TILES_DOWN   = 3'd1,
		REG_CROP_TOP     = 3'd2,
		REG_CROP_BOTTOM  = 3'd3,
		REG_CROP_LEFT    = 3'd4,
		REG_CROP_RIGHT   = 3'd5
	} cfg_reg_t;

	// Reset values of the registers.
	localparam logic [COUNT_W-1:0] TILES_RESET     = COUNT_W'(1);
	localparam logic [CROP_W-1:0]  CROP_LOW_RESET  = CROP_W'(0);
	localparam logic [CROP_W-1:0]  CROP_HIGH_RESET = CROP_W'(4096);

	// BT.601 integer coefficients, scaled by 256.
	localparam int COEF_Y   = 298;
	localparam int COEF_RV  = 409;
	localparam int COEF_GU  = 100;
	localparam int COEF_GV  = 208;
	localparam int COEF_BU  = 517;
	localparam int LUMA_OFS = 16;
	localparam int CHROMA_OFS = 128;

	// Position of a pixel pair in the raster picture.
	typedef struct packed {
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             done;
	} pos_t;

	// One input beat.
	typedef struct packed {
		logic [7:0] chroma_v;
		logic [7:0] chroma_u;
		logic [7:0] luma_second;
		logic [7:0] luma_first;
	} pair_in_t;

	// A tile count of zero counts as one, and one above the limit as the limit.
	function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] v,
			input logic [COUNT_W:0] maxv);
		logic [COUNT_W-1:0] r;
		if (v == '0) begin
			r = COUNT_W'(1);
		end else if ({1'b0, v} > maxv) begin
			r = maxv[COUNT_W-1:0];
		end else begin
			r = v;
		end
		return r;
	endfunction

	// Divide by 256 and saturate to 0..255.
	function automatic logic [7:0] clip_div256(input logic signed [SUM_W-1:0] s);
		logic [7:0] r;
		if (s[SUM_W-1]) begin
			r = 8'd0;
		end else if (s[SUM_W-2:16] != '0) begin
			r = 8'hff;
		end else begin
			r = s[15:8];
		end
		return r;
	endfunction

endpackage

/* rtl/core/tiled_yuv420_to_rgb565.sv */
// Top level of the tiled YUV 4:2:0 to RGB565 pixel pair converter.
//
// Input beats arrive on the s_ stream in 32x32 tile order: pairs left to right
// in a tile line, lines top to bottom in a tile, tiles left to right, then tile
// rows top to bottom. Each beat carries two luma bytes and the shared U and V.
// Each beat yields exactly one output beat on the m_ stream: two RGB565 pixels
// and the raster index of the even pixel; m_tlast marks the last pair of a frame.
// The cfg_ write channel sets the tile counts and the crop window; it is always
// ready and should only be written while no beat is in flight.
// Throughput is one beat per clock while the receiver is ready. An accepted
// beat lands in the input stage, and its result is then loaded into the output
// register, from which it leaves on the m_ stream.
// The conversion, crop test and index multiply all sit in the single path
// between those two registers.
// When the receiver stalls, the output register holds; a beat can still be
// taken into the empty input stage, and s_tready drops once both are full.
// Reset clears the position counters to the first pair of a frame, empties the
// pipeline and restores the register defaults (one tile each way, full window).
module tiled_yuv420_to_rgb565 (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration write channel.
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tyr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tyr_pkg::CROP_W-1:0]     cfg_data,
	// Input stream.
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [31:0]                    s_tdata,  // luma_first, luma_second, chroma_u, chroma_v
	// Output stream.
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [55:0]                    m_tdata,  // pixel_pair[31:0], dest_index[55:32]
	output logic                           m_tlast   // frame_done
);

	logic [tyr_pkg::COUNT_W-1:0]  tiles_across_q;
	logic [tyr_pkg::COUNT_W-1:0]  tiles_down_q;
	logic [tyr_pkg::CROP_W-1:0]   crop_top_q;
	logic [tyr_pkg::CROP_W-1:0]   crop_bottom_q;
	logic [tyr_pkg::CROP_W-1:0]   crop_left_q;
	logic [tyr_pkg::CROP_W-1:0]   crop_right_q;
	logic [tyr_pkg::COUNT_W-1:0]  across;
	logic [tyr_pkg::COUNT_W-1:0]  down;

	tyr_pkg::pos_t                pos;
	logic                         in_beat;
	logic                         adv_s1;
	logic                         adv_s2;

	logic                         valid_s1;
	tyr_pkg::pair_in_t            pair_s1;
	tyr_pkg::pos_t                pos_s1;

	logic                         valid_s2;
	logic [31:0]                  pixel_pair_s2;
	logic [tyr_pkg::INDEX_W-1:0]  dest_index_s2;
	logic                         frame_done_s2;

	logic [tyr_pkg::STRIDE_W-1:0] stride;
	logic [24:0]                  row_offset;
	logic [tyr_pkg::INDEX_W-1:0]  dest_index;
	logic [tyr_pkg::CROP_W-1:0]   row_ext;
	logic [tyr_pkg::CROP_W-1:0]   col0_ext;
	logic [tyr_pkg::CROP_W-1:0]   col1_ext;
	logic                         row_ok;
	logic                         vis0;
	logic                         vis1;
	logic [15:0]                  rgb0;
	logic [15:0]                  rgb1;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tiles_across_q <= tyr_pkg::TILES_RESET;
			tiles_down_q   <= tyr_pkg::TILES_RESET;
			crop_top_q     <= tyr_pkg::CROP_LOW_RESET;
			crop_bottom_q  <= tyr_pkg::CROP_HIGH_RESET;
			crop_left_q    <= tyr_pkg::CROP_LOW_RESET;
			crop_right_q   <= tyr_pkg::CROP_HIGH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tyr_pkg::REG_TILES_ACROSS: tiles_across_q <= cfg_data[tyr_pkg::COUNT_W-1:0];
				tyr_pkg::REG_TILES_DOWN:   tiles_down_q   <= cfg_data[tyr_pkg::COUNT_W-1:0];
				tyr_pkg::REG_CROP_TOP:     crop_top_q     <= cfg_data;
				tyr_pkg::REG_CROP_BOTTOM:  crop_bottom_q  <= cfg_data;
				tyr_pkg::REG_CROP_LEFT:    crop_left_q    <= cfg_data;
				tyr_pkg::REG_CROP_RIGHT:   crop_right_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign across = tyr_pkg::clamp_count(tiles_across_q,
		(tyr_pkg::COUNT_W + 1)'(tyr_pkg::MAX_TILES_ACROSS));
	assign down   = tyr_pkg::clamp_count(tiles_down_q,
		(tyr_pkg::COUNT_W + 1)'(tyr_pkg::MAX_TILES_DOWN));

	// Pipeline flow control: each stage moves when the one after it is free.
	assign adv_s2   = !valid_s2 || m_tready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign s_tready = adv_s1;
	assign in_beat  = s_tvalid && s_tready;

	tyr_tile_cnt u_tile_cnt (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (in_beat),
		.across  (across),
		.down    (down),
		.pos     (pos)
	);

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			pair_s1 <= s_tdata;
			pos_s1  <= pos;
		end
	end

	// Crop test, raster index and color conversion.
	assign row_ext  = {1'b0, pos_s1.row};
	assign col0_ext = {1'b0, pos_s1.col};
	assign col1_ext = {1'b0, pos_s1.col} + tyr_pkg::CROP_W'(1);
	assign row_ok   = (row_ext >= crop_top_q) && (row_ext < crop_bottom_q);
	assign vis0     = row_ok && (col0_ext >= crop_left_q) && (col0_ext < crop_right_q);
	assign vis1     = row_ok && (col1_ext >= crop_left_q) && (col1_ext < crop_right_q);

	assign stride     = {across, 5'b00000};
	assign row_offset = 25'(pos_s1.row) * 25'(stride);
	assign dest_index = tyr_pkg::INDEX_W'(row_offset + 25'(pos_s1.col));

	tyr_pixel_cvt u_cvt_even (
		.luma     (pair_s1.luma_first),
		.chroma_u (pair_s1.chroma_u),
		.chroma_v (pair_s1.chroma_v),
		.visible  (vis0),
		.rgb      (rgb0)
	);

	tyr_pixel_cvt u_cvt_odd (
		.luma     (pair_s1.luma_second),
		.chroma_u (pair_s1.chroma_u),
		.chroma_v (pair_s1.chroma_v),
		.visible  (vis1),
		.rgb      (rgb1)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			pixel_pair_s2 <= {rgb1, rgb0};
			dest_index_s2 <= dest_index;
			frame_done_s2 <= pos_s1.done;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {dest_index_s2, pixel_pair_s2};
	assign m_tlast  = frame_done_s2;

	// After the last pair of a frame the counters restart at the first pair.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && pos.done |=> pos.row == '0 && pos.col == '0)
		else $error("position counters did not wrap after the last pair of a frame");

	// An empty output register never holds off the input.
	assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> s_tready)
		else $error("input stalled while the output register is empty");

	// With both stages full and the receiver stalled, no beat may enter.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !m_tready |-> !s_tready)
		else $error("input accepted while the pipeline is full and stalled");

endmodule

/* rtl/core/tyr_pixel_cvt.sv */
// Converts one YUV pixel to RGB565, forced to zero outside the crop window.
module tyr_pixel_cvt (
	input  logic [7:0]  luma,
	input  logic [7:0]  chroma_u,
	input  logic [7:0]  chroma_v,
	input  logic        visible,
	output logic [15:0] rgb
);

	logic signed [9:0]                 c;
	logic signed [9:0]                 d;
	logic signed [9:0]                 e;
	logic signed [tyr_pkg::SUM_W-1:0] luma_term;
	logic signed [tyr_pkg::SUM_W-1:0] sum_r;
	logic signed [tyr_pkg::SUM_W-1:0] sum_g;
	logic signed [tyr_pkg::SUM_W-1:0] sum_b;
	logic [7:0]                        r;
	logic [7:0]                        g;
	logic [7:0]                        b;

	always_comb begin
		c = $signed({2'b00, luma}) - 10'(tyr_pkg::LUMA_OFS);
		d = $signed({2'b00, chroma_u}) - 10'(tyr_pkg::CHROMA_OFS);
		e = $signed({2'b00, chroma_v}) - 10'(tyr_pkg::CHROMA_OFS);
		luma_term = tyr_pkg::SUM_W'(c) * tyr_pkg::SUM_W'(tyr_pkg::COEF_Y);
		sum_r = luma_term + tyr_pkg::SUM_W'(e) * tyr_pkg::SUM_W'(tyr_pkg::COEF_RV);
		sum_g = luma_term - tyr_pkg::SUM_W'(d) * tyr_pkg::SUM_W'(tyr_pkg::COEF_GU)
			- tyr_pkg::SUM_W'(e) * tyr_pkg::SUM_W'(tyr_pkg::COEF_GV);
		sum_b = luma_term + tyr_pkg::SUM_W'(d) * tyr_pkg::SUM_W'(tyr_pkg::COEF_BU);
		r = tyr_pkg::clip_div256(sum_r);
		g = tyr_pkg::clip_div256(sum_g);
		b = tyr_pkg::clip_div256(sum_b);
		rgb = visible ? {r[7:3], g[7:2], b[7:3]} : 16'd0;
	end

endmodule

/* rtl/core/tyr_tile_cnt.sv */
// Tile-order position counters: pair, line, tile column and tile row.
module tyr_tile_cnt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         advance,
	input  logic [tyr_pkg::COUNT_W-1:0]  across,
	input  logic [tyr_pkg::COUNT_W-1:0]  down,
	output tyr_pkg::pos_t                pos
);

	logic [tyr_pkg::TILE_W-1:0] tile_column_q;
	logic [tyr_pkg::TILE_W-1:0] tile_row_q;
	logic [tyr_pkg::LINE_W-1:0] line_q;
	logic [tyr_pkg::PAIR_W-1:0] pair_q;
	logic                       last_pair;
	logic                       last_line;
	logic                       last_col;
	logic                       last_row;

	// A counter at or beyond a shrunken tile count is treated as on its last tile.
	assign last_pair = &pair_q;
	assign last_line = &line_q;
	assign last_col  = ({1'b0, tile_column_q} + tyr_pkg::COUNT_W'(1)) >= across;
	assign last_row  = ({1'b0, tile_row_q} + tyr_pkg::COUNT_W'(1)) >= down;

	assign pos.row  = {tile_row_q, line_q};
	assign pos.col  = {tile_column_q, pair_q, 1'b0};
	assign pos.done = last_pair && last_line && last_col && last_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_column_q <= '0;
			tile_row_q    <= '0;
			line_q        <= '0;
			pair_q        <= '0;
		end else if (advance) begin
			pair_q <= pair_q + 1'b1;
			if (last_pair) begin
				line_q <= line_q + 1'b1;
				if (last_line) begin
					if (!last_col) begin
						tile_column_q <= tile_column_q + 1'b1;
					end else begin
						tile_column_q <= '0;
						tile_row_q    <= last_row ? '0 : tile_row_q + 1'b1;
					end
				end
			end
		end
	end

endmodule
